// File: hw/rtl/yoca_pkg.sv
`timescale 1ns / 1ps

package yoca_pkg;

    localparam int YEAR_W = 14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_INIT,
        ST_DIV_RUN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic acc;        // fold the input sample into the group
        logic pend_load;  // hold the input sample for the next group
        logic start_pend; // open a group from the held sample
        logic clear;      // drop all group state
        logic div_init;
        logic div_step;
        logic emit_load;
        logic emit_last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic boundary;   // input year differs from an open group
        logic div_done;
        logic out_busy;
    } dp_status_t;

endpackage

// File: hw/rtl/yoca_ctrl.sv
`timescale 1ns / 1ps

module yoca_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   s_tlast,
    input  yoca_pkg::dp_status_t   status,
    output yoca_pkg::ctrl_cmd_t    cmd
);
    import yoca_pkg::*;

    state_t state_reg, state_next;
    logic   pend_start_reg, pend_start_next;
    logic   pend_end_reg, pend_end_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_start_reg <= 1'b0;
            pend_end_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_start_reg <= pend_start_next;
            pend_end_reg   <= pend_end_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        cmd             = '0;
        s_tready        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (status.boundary)
                    begin
                        cmd.pend_load   = 1'b1;
                        pend_start_next = 1'b1;
                        pend_end_next   = s_tlast;
                        state_next      = ST_DIV_INIT;
                    end
                    else
                    begin
                        cmd.acc = 1'b1;
                        if (s_tlast)
                        begin
                            pend_start_next = 1'b0;
                            pend_end_next   = 1'b1;
                            state_next      = ST_DIV_INIT;
                        end
                    end
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit_load = 1'b1;
                    cmd.emit_last = !(pend_start_reg && pend_end_reg);
                    if (pend_start_reg)
                    begin
                        cmd.start_pend  = 1'b1;
                        pend_start_next = 1'b0;
                        state_next      = pend_end_reg ? ST_DIV_INIT : ST_IDLE;
                    end
                    else
                    begin
                        cmd.clear     = pend_end_reg;
                        pend_end_next = 1'b0;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/yoca_datapath.sv
`timescale 1ns / 1ps

module yoca_datapath #(
    parameter int TEMP_BITS   = 16,
    parameter int MAX_SAMPLES = 16384,
    parameter int IN_DW       = 32,
    parameter int OUT_DW      = 80
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DW-1:0]      s_tdata,
    input  yoca_pkg::ctrl_cmd_t   cmd,
    output yoca_pkg::dp_status_t  status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DW-1:0]     m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);
    import yoca_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W  = TEMP_BITS + CNT_W;
    localparam int DCW    = $clog2(SUM_W + 1);

    logic [YEAR_W-1:0]           in_year;
    logic signed [TEMP_BITS-1:0] in_temp;

    logic [YEAR_W-1:0]           year_reg;
    logic                        active_reg;
    logic signed [SUM_W-1:0]     sum_reg;
    logic [CNT_W-1:0]            count_reg;
    logic signed [TEMP_BITS-1:0] max_reg, min_reg, first_reg;
    logic signed [TEMP_BITS-1:0] prior_reg;
    logic                        prior_valid_reg;
    logic                        ovf_reg;

    logic [YEAR_W-1:0]           pend_year_reg;
    logic signed [TEMP_BITS-1:0] pend_temp_reg;

    logic [SUM_W-1:0]            quo_reg;
    logic [CNT_W-1:0]            rem_reg;
    logic [DCW-1:0]              div_cnt_reg;
    logic                        neg_reg;
    logic [CNT_W:0]              rem_shift;
    logic                        rem_ge;
    logic [CNT_W:0]              rem_diff;
    logic [SUM_W-1:0]            quo_signed;
    logic signed [TEMP_BITS-1:0] close_val;
    logic signed [TEMP_BITS-1:0] open_val;

    logic                        out_valid_reg;
    logic [OUT_DW-1:0]           out_data_reg;
    logic                        out_user_reg;
    logic                        out_last_reg;

    assign in_year = s_tdata[YEAR_W-1:0];
    assign in_temp = s_tdata[YEAR_W +: TEMP_BITS];

    assign status.boundary = active_reg && (in_year != year_reg);
    assign status.div_done = (div_cnt_reg == DCW'(1));
    assign status.out_busy = out_valid_reg && !m_tready;

    assign rem_shift  = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_ge     = (rem_shift >= {1'b0, count_reg});
    assign rem_diff   = rem_shift - {1'b0, count_reg};
    assign quo_signed = neg_reg ? (~quo_reg + SUM_W'(1)) : quo_reg;
    assign close_val  = quo_signed[TEMP_BITS-1:0];
    assign open_val   = prior_valid_reg ? prior_reg : first_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            prior_valid_reg <= 1'b0;
            ovf_reg         <= 1'b0;
            year_reg        <= '0;
            sum_reg         <= '0;
            count_reg       <= '0;
            max_reg         <= '0;
            min_reg         <= '0;
            first_reg       <= '0;
            prior_reg       <= '0;
        end
        else
        begin
            if (cmd.emit_load && !cmd.clear)
            begin
                prior_reg       <= close_val;
                prior_valid_reg <= 1'b1;
            end
            if (cmd.clear)
            begin
                active_reg      <= 1'b0;
                prior_valid_reg <= 1'b0;
                ovf_reg         <= 1'b0;
                year_reg        <= '0;
                sum_reg         <= '0;
                count_reg       <= '0;
                max_reg         <= '0;
                min_reg         <= '0;
                first_reg       <= '0;
                prior_reg       <= '0;
            end
            else if (cmd.start_pend || (cmd.acc && !active_reg))
            begin
                active_reg <= 1'b1;
                ovf_reg    <= 1'b0;
                count_reg  <= CNT_W'(1);
                if (cmd.start_pend)
                begin
                    year_reg  <= pend_year_reg;
                    sum_reg   <= SUM_W'(pend_temp_reg);
                    max_reg   <= pend_temp_reg;
                    min_reg   <= pend_temp_reg;
                    first_reg <= pend_temp_reg;
                end
                else
                begin
                    year_reg  <= in_year;
                    sum_reg   <= SUM_W'(in_temp);
                    max_reg   <= in_temp;
                    min_reg   <= in_temp;
                    first_reg <= in_temp;
                end
            end
            else if (cmd.acc)
            begin
                if (count_reg < CNT_W'(MAX_SAMPLES))
                begin
                    sum_reg   <= sum_reg + SUM_W'(in_temp);
                    count_reg <= count_reg + CNT_W'(1);
                    if (in_temp > max_reg)
                    begin
                        max_reg <= in_temp;
                    end
                    if (in_temp < min_reg)
                    begin
                        min_reg <= in_temp;
                    end
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pend_load)
        begin
            pend_year_reg <= in_year;
            pend_temp_reg <= in_temp;
        end
    end

    // restoring divide on |sum|, one quotient bit a cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_init)
        begin
            div_cnt_reg <= DCW'(SUM_W);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            neg_reg <= sum_reg[SUM_W-1];
            quo_reg <= sum_reg[SUM_W-1] ? (~sum_reg + SUM_W'(1)) : sum_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[SUM_W-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_data_reg <= OUT_DW'({close_val, min_reg, max_reg, open_val, year_reg});
            out_user_reg <= ovf_reg;
            out_last_reg <= cmd.emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hw/rtl/yearly_ohlc_candle_aggregator.sv
`timescale 1ns / 1ps

// channel  dir  tdata (low bit up)                      tuser           tlast
// s_*      in   sample_year, sample_temp                -               end_of_data
// m_*      out  candle_year, open, high, low, close     count_overflow  last_of_run
//
// Samples inside a year are taken one per cycle.
// A candle holds input off while the divider is loaded, stepped once per quotient bit
// (TEMP_BITS + clog2(MAX_SAMPLES_PER_GROUP+1) bits) and the output is loaded.
// A year change together with the end mark runs the divider twice.
// A held output delays only the loading of the next candle; input waits then too.
// Reset clears all group state; no clearing pass.
module yearly_ohlc_candle_aggregator #(
    parameter int MAX_SAMPLES_PER_GROUP = 16384,
    parameter int TEMP_BITS             = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // sample_year, sample_temp, unused pad
    input  logic [((yoca_pkg::YEAR_W + TEMP_BITS + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    // candle_year, open_temp, high_temp, low_temp, close_temp, zero pad
    output logic [((yoca_pkg::YEAR_W + 4 * TEMP_BITS + 7) / 8) * 8 - 1:0] m_tdata,
    // count_overflow
    output logic                m_tuser,
    output logic                m_tlast
);
    import yoca_pkg::*;

    localparam int IN_DW  = ((YEAR_W + TEMP_BITS + 7) / 8) * 8;
    localparam int OUT_DW = ((YEAR_W + 4 * TEMP_BITS + 7) / 8) * 8;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    yoca_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tlast  (s_tlast),
        .status   (status),
        .cmd      (cmd)
    );

    yoca_datapath #(
        .TEMP_BITS   (TEMP_BITS),
        .MAX_SAMPLES (MAX_SAMPLES_PER_GROUP),
        .IN_DW       (IN_DW),
        .OUT_DW      (OUT_DW)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .status   (status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: tb/sv/yearly_ohlc_candle_aggregator_tb.sv
`timescale 1ns / 1ps

module yearly_ohlc_candle_aggregator_tb;

    localparam int YW        = yoca_pkg::YEAR_W;
    localparam int TW        = 16;
    localparam int MAX_GROUP = 16384;
    localparam int DW_IN     = ((YW + TW + 7) / 8) * 8;
    localparam int DW_OUT    = ((YW + 4 * TW + 7) / 8) * 8;
    localparam int LIMIT     = 1000000;
    localparam int HOLD_LEN  = 400;
    localparam int TAIL      = 100;

    typedef struct packed {
        logic [YW-1:0]        s_year;
        logic signed [TW-1:0] s_temp;
        logic                 s_end;
    } sample_t;

    typedef struct packed {
        logic [YW-1:0]        c_year;
        logic signed [TW-1:0] c_open;
        logic signed [TW-1:0] c_high;
        logic signed [TW-1:0] c_low;
        logic signed [TW-1:0] c_close;
        logic                 c_ovf;
        logic                 c_last;
    } candle_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DW_IN-1:0]  s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DW_OUT-1:0] m_tdata;
    logic              m_tuser;
    logic              m_tlast;

    yearly_ohlc_candle_aggregator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_t sample_q[$];
    candle_t candle_q[$];
    sample_t in_flight;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_req = 1'b0;
    int hold_left;
    int cycle_cnt = 0;
    int mismatches = 0;
    int samples_taken = 0;
    int candles_seen = 0;
    int ovf_candles = 0;
    int double_items = 0;

    // group tracker
    logic [YW-1:0]        g_year;
    logic                 g_active;
    int                   g_sum;
    int                   g_count;
    logic signed [TW-1:0] g_max;
    logic signed [TW-1:0] g_min;
    logic signed [TW-1:0] g_first;
    logic signed [TW-1:0] g_prior;
    logic                 g_prior_ok;
    logic                 g_ovf;

    function automatic bit coin(int pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic clear_group();
        g_year     = '0;
        g_active   = 1'b0;
        g_sum      = 0;
        g_count    = 0;
        g_max      = '0;
        g_min      = '0;
        g_first    = '0;
        g_prior    = '0;
        g_prior_ok = 1'b0;
        g_ovf      = 1'b0;
    endtask

    task automatic open_group(sample_t s);
        g_year   = s.s_year;
        g_active = 1'b1;
        g_sum    = int'(s.s_temp);
        g_count  = 1;
        g_max    = s.s_temp;
        g_min    = s.s_temp;
        g_first  = s.s_temp;
        g_ovf    = 1'b0;
    endtask

    function automatic candle_t close_group();
        candle_t c;
        int mean;
        mean      = g_sum / g_count;
        c.c_year  = g_year;
        c.c_open  = g_prior_ok ? g_prior : g_first;
        c.c_high  = g_max;
        c.c_low   = g_min;
        c.c_close = mean[TW-1:0];
        c.c_ovf   = g_ovf;
        c.c_last  = 1'b0;
        g_prior    = mean[TW-1:0];
        g_prior_ok = 1'b1;
        return c;
    endfunction

    task automatic fold_sample(sample_t s);
        candle_t made[2];
        int n;
        n = 0;
        if (g_active && s.s_year != g_year)
        begin
            made[n] = close_group();
            n++;
            open_group(s);
        end
        else if (g_active)
        begin
            if (g_count < MAX_GROUP)
            begin
                g_sum += int'(s.s_temp);
                g_count++;
                if (s.s_temp > g_max)
                    g_max = s.s_temp;
                if (s.s_temp < g_min)
                    g_min = s.s_temp;
            end
            else
                g_ovf = 1'b1;
        end
        else
            open_group(s);
        if (s.s_end)
        begin
            made[n] = close_group();
            n++;
            clear_group();
        end
        if (n > 0)
            made[n-1].c_last = 1'b1;
        if (n == 2)
            double_items++;
        for (int i = 0; i < n; i++)
            candle_q = {candle_q, made[i]};
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin : drv_proc
        logic busy;
        logic [DW_IN-1:0] word;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            busy = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                fold_sample(in_flight);
                samples_taken++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (sample_q.size() != 0 && !coin(tx_idle_pct))
                begin
                    in_flight = sample_q.pop_front();
                    word = DW_IN'($urandom);
                    word[YW-1:0] = in_flight.s_year;
                    word[YW+TW-1:YW] = in_flight.s_temp;
                    s_tvalid <= 1'b1;
                    s_tdata  <= word;
                    s_tlast  <= in_flight.s_end;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_req)
            hold_left <= HOLD_LEN;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin : mon_proc
        candle_t got;
        candle_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.c_year  = m_tdata[YW-1:0];
                got.c_open  = m_tdata[YW+TW-1:YW];
                got.c_high  = m_tdata[YW+2*TW-1:YW+TW];
                got.c_low   = m_tdata[YW+3*TW-1:YW+2*TW];
                got.c_close = m_tdata[YW+4*TW-1:YW+3*TW];
                got.c_ovf   = m_tuser;
                got.c_last  = m_tlast;
                candles_seen++;
                if (got.c_ovf)
                    ovf_candles++;
                if (candle_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected candle: year %0d o %0d h %0d l %0d c %0d ovf %0b last %0b",
                                 got.c_year, got.c_open, got.c_high, got.c_low, got.c_close,
                                 got.c_ovf, got.c_last);
                end
                else
                begin
                    want = candle_q.pop_front();
                    if (got.c_year != want.c_year || got.c_open != want.c_open
                        || got.c_high != want.c_high || got.c_low != want.c_low
                        || got.c_close != want.c_close || got.c_ovf != want.c_ovf
                        || got.c_last != want.c_last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("candle mismatch at cycle %0d", cycle_cnt);
                            $display("  exp: year %0d o %0d h %0d l %0d c %0d ovf %0b last %0b",
                                     want.c_year, want.c_open, want.c_high, want.c_low,
                                     want.c_close, want.c_ovf, want.c_last);
                            $display("  got: year %0d o %0d h %0d l %0d c %0d ovf %0b last %0b",
                                     got.c_year, got.c_open, got.c_high, got.c_low,
                                     got.c_close, got.c_ovf, got.c_last);
                        end
                    end
                end
            end
            m_tready <= (hold_left == 0) && !coin(rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILED: results differ");
            $finish;
        end
    end

    task automatic add_sample(int year, logic signed [TW-1:0] temp, bit last);
        sample_t s;
        s.s_year = YW'(year);
        s.s_temp = temp;
        s.s_end  = last;
        sample_q = {sample_q, s};
    endtask

    function automatic logic signed [TW-1:0] pick_temp();
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2, 3, 4: return TW'($urandom_range(100)) - TW'(50);
            default: return TW'($urandom);
        endcase
    endfunction

    function automatic int next_year(int year);
        return (year == 9999) ? 0 : year + 1;
    endfunction

    task automatic add_random_runs(int n);
        int year;
        int run;
        int k;
        bit last;
        year = $urandom_range(9999);
        k = 0;
        while (k < n)
        begin
            run = ($urandom_range(9) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
            for (int i = 0; i < run && k < n; i++)
            begin
                last = ($urandom_range(39) == 0);
                add_sample(year, pick_temp(), last);
                k++;
            end
            case ($urandom_range(9))
                0, 1: year = $urandom_range(9999);
                2: year = year;
                default: year = next_year(year);
            endcase
        end
        add_sample(year, pick_temp(), 1'b1);
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || s_tvalid || candle_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int year;
        clear_group();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct <= 28;
        rx_idle_pct <= 56;
        @(posedge clk);

        // single-sample groups at the field extremes, then a group mixing both extremes
        add_sample(0, 16'sh8000, 1'b1);
        add_sample(9999, 16'sh7fff, 1'b1);
        add_sample(5, 16'sh7fff, 1'b0);
        add_sample(5, 16'sh8000, 1'b0);
        add_sample(5, 16'sh0001, 1'b0);
        // negative mean truncates toward zero
        add_sample(6, -16'sd1, 1'b0);
        add_sample(6, -16'sd2, 1'b0);
        // year change together with the end mark
        add_sample(7, 16'sh8000, 1'b1);
        add_sample(3, 16'sd5, 1'b0);
        add_sample(3, 16'sd6, 1'b1);
        add_sample(9999, 16'sh7fff, 1'b0);
        add_sample(9999, 16'sh7fff, 1'b0);
        add_sample(9999, 16'sh7fff, 1'b0);
        add_sample(9998, 16'sh8000, 1'b0);
        add_sample(9998, 16'sh8000, 1'b0);
        add_sample(9998, 16'sh7fff, 1'b0);
        add_sample(0, 16'sd100, 1'b0);
        add_sample(0, -16'sd101, 1'b1);
        add_sample(4660, -16'sd7, 1'b0);
        add_sample(4661, -16'sd7, 1'b0);
        add_sample(4662, -16'sd7, 1'b0);
        add_sample(4663, -16'sd7, 1'b1);
        add_random_runs(420);
        wait_drained();

        // output held off while a candle per transaction is offered
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
        year = $urandom_range(9000);
        for (int i = 0; i < 60; i++)
            add_sample(year + i, pick_temp(), i == 59);
        add_random_runs(60);
        wait_drained();

        tx_idle_pct <= 56;
        rx_idle_pct <= 28;
        add_random_runs(450);
        wait_drained();

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        add_random_runs(450);

        wait_drained();
        repeat (TAIL) @(posedge clk);

        $display("covered %0d samples, %0d candles, %0d with dropped samples, %0d double flushes",
                 samples_taken, candles_seen, ovf_candles, double_items);
        $display("idle mixes on both sides, a long output hold-off and year changes at the end mark");
        if (mismatches == 0 && candle_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
